### src/pgmog_pkg.sv
// pgmog_pkg: shared types, codes and helpers of the pgm to occupancy grid decoder
// no dependencies

package pgmog_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int FIFO_DEPTH = 4;

  // result kinds
  localparam logic [1:0] KIND_CELL   = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  // error codes
  localparam logic [2:0] ERR_MAGIC  = 3'd0;
  localparam logic [2:0] ERR_HEADER = 3'd1;
  localparam logic [2:0] ERR_ZERO   = 3'd2;
  localparam logic [2:0] ERR_LARGE  = 3'd3;
  localparam logic [2:0] ERR_SHORT  = 3'd4;

  // parse phases
  localparam logic [3:0] PH_MAGIC_WS  = 4'd0;
  localparam logic [3:0] PH_MAGIC_P   = 4'd1;
  localparam logic [3:0] PH_MAGIC_END = 4'd2;
  localparam logic [3:0] PH_HDR_W     = 4'd3;
  localparam logic [3:0] PH_HDR_H     = 4'd4;
  localparam logic [3:0] PH_HDR_MAX   = 4'd5;
  localparam logic [3:0] PH_DATA8     = 4'd6;
  localparam logic [3:0] PH_DATA16_HI = 4'd7;
  localparam logic [3:0] PH_DATA16_LO = 4'd8;
  localparam logic [3:0] PH_P2_DATA   = 4'd9;
  localparam logic [3:0] PH_DRAIN     = 4'd10;

  // token stages
  localparam logic [1:0] TOK_SKIP  = 2'd0;
  localparam logic [1:0] TOK_SIGN  = 2'd1;
  localparam logic [1:0] TOK_DIGIT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_NEGATE = 2'd0;
  localparam logic [1:0] CFG_OCC    = 2'd1;
  localparam logic [1:0] CFG_FREE   = 2'd2;

  localparam logic [15:0] OCC_RESET  = 16'd42598;
  localparam logic [15:0] FREE_RESET = 16'd12845;

  // one queued result; pix is the raw sample, classified downstream
  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] idx;
    logic [15:0] pix;
    logic [12:0] w;
    logic [12:0] h;
    logic [15:0] m;
    logic [2:0]  err;
    logic        last;
  } pgmog_rec_t;

  // parser state
  typedef struct packed {
    logic [3:0]  phase;
    logic        binfmt;
    logic        comment;
    logic [16:0] acc;
    logic        neg;
    logic [1:0]  tstage;
    logic [12:0] w;
    logic [12:0] h;
    logic [15:0] m;
    logic [11:0] col;
    logic [23:0] rowb;
    logic [7:0]  hold;
    logic [24:0] prem;
  } pgmog_state_t;

  function automatic pgmog_rec_t pgmog_mk(logic [1:0] kind, logic [23:0] idx,
                                          logic [15:0] pix, logic [2:0] err,
                                          logic last, pgmog_state_t s);
    pgmog_rec_t r;
    r.kind = kind;
    r.idx  = idx;
    r.pix  = pix;
    r.w    = s.w;
    r.h    = s.h;
    r.m    = s.m;
    r.err  = err;
    r.last = last;
    return r;
  endfunction

endpackage

### src/pgm_to_occupancy_grid_decoder_top.sv
// pgm_to_occupancy_grid_decoder_top: pgm byte stream to occupancy cells
// depends on pgmog_pkg, pgmog_parser, pgmog_fifo, pgmog_classify
//
// Usage:
//   file bytes enter on in_valid/in_ready with file_byte and end_of_file,
//   one request per cycle while in_ready is high. Each byte yields zero,
//   one or two results (cell, header, error, done) on out_valid/out_ready.
//   Results are classified 100/0/-1 against the Q0.16 thresholds; the user
//   must see that these are written through cfg_we/cfg_index/cfg_data only
//   while the block is idle, as the block itself does not enforce it.
//   A byte's results are queued at the accepting edge, then registered in
//   the threshold-product stage, then compared into the output register.
//   Throughput: one byte per cycle while in_ready is high; the rate is set
//   by the single output port, so bytes that make two results fill the queue.
//   in_ready depends only on the fill level of a four-entry result queue:
//   the byte is taken while at least two entries are free.
//   When the receiver stalls, the output register holds its result, the
//   queue fills and in_ready drops; nothing is lost or repeated.
//   Reset (rst, synchronous) empties the queue and pipeline, returns the
//   parser to expecting the magic, and restores the default thresholds.
//   end_of_file on an accepted byte always returns the parser to the start of a new file.

module pgm_to_occupancy_grid_decoder_top import pgmog_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        file_byte,
  input  logic              end_of_file,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        result_kind,
  output logic [23:0]       cell_index,
  output logic signed [7:0] occupancy,
  output logic [12:0]       image_width,
  output logic [12:0]       image_height,
  output logic [15:0]       max_value,
  output logic [2:0]        error_code,
  output logic              last_result
);

  logic       take, q_valid, q_room, q_pop;
  logic [1:0] push_count;
  pgmog_rec_t push_rec0, push_rec1, q_head;

  assign in_ready = q_room;
  assign take     = in_valid && in_ready;

  // byte parser
  pgmog_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .file_byte   (file_byte),
    .end_of_file (end_of_file),
    .push_count  (push_count),
    .push_rec0   (push_rec0),
    .push_rec1   (push_rec1)
  );

  // result queue
  pgmog_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push_rec0  (push_rec0),
    .push_rec1  (push_rec1),
    .pop        (q_pop),
    .not_empty  (q_valid),
    .has_room   (q_room),
    .head       (q_head)
  );

  // classification and output
  pgmog_classify u_classify (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rec_valid    (q_valid),
    .rec          (q_head),
    .rec_pop      (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .cell_index   (cell_index),
    .occupancy    (occupancy),
    .image_width  (image_width),
    .image_height (image_height),
    .max_value    (max_value),
    .error_code   (error_code),
    .last_result  (last_result)
  );

endmodule

### src/pgmog_parser.sv
// pgmog_parser: byte-level pgm parse state machine, up to two results per byte
// depends on pgmog_pkg

module pgmog_parser import pgmog_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] file_byte,
  input  logic       end_of_file,
  output logic [1:0] push_count,
  output pgmog_rec_t push_rec0,
  output pgmog_rec_t push_rec1
);

  pgmog_state_t st, st_next, s;
  pgmog_rec_t   res [2];
  logic [1:0]   nres;
  logic         redo, fin, px, lo16, failf, consumed, digit, space;
  logic [2:0]   fcode, nerr;
  logic [3:0]   dval;
  logic [20:0]  v;
  logic [12:0]  sat13;
  logic [25:0]  area;
  logic [15:0]  pixv;
  logic [16:0]  negacc;

  assign digit = (file_byte >= 8'h30) && (file_byte <= 8'h39);
  assign space = (file_byte == 8'h20) || ((file_byte >= 8'd9) && (file_byte <= 8'd13));
  assign dval  = 4'(file_byte - 8'h30);

  // parse one byte, with a second look when a number ends on it
  always_comb begin
    s = st;
    res[0] = '0;
    res[1] = '0;
    nres = 2'd0;
    redo = 1'b1;
    fin = 1'b0; px = 1'b0; lo16 = 1'b0; failf = 1'b0; consumed = 1'b1;
    fcode = ERR_MAGIC; nerr = ERR_HEADER; v = '0; sat13 = '0; area = '0;
    pixv = '0; negacc = '0;
    for (int pass = 0; pass < 3; pass++) begin
      fin = 1'b0; px = 1'b0; lo16 = 1'b0; failf = 1'b0;
      nerr = (s.phase == PH_P2_DATA) ? ERR_SHORT : ERR_HEADER;
      if (pass < 2 && redo) begin
        redo = 1'b0;
        unique case (s.phase)
          PH_MAGIC_WS: begin
            if (file_byte == 8'h50) s.phase = PH_MAGIC_P;
            else if (!space) begin failf = 1'b1; fcode = ERR_MAGIC; end
          end
          PH_MAGIC_P: begin
            if (file_byte == 8'h35 || file_byte == 8'h32) begin
              s.binfmt = (file_byte == 8'h35);
              s.phase = PH_MAGIC_END;
            end else begin
              failf = 1'b1; fcode = ERR_MAGIC;
            end
          end
          PH_MAGIC_END: begin
            if (space) begin s.phase = PH_HDR_W; s.tstage = TOK_SKIP; end
            else begin failf = 1'b1; fcode = ERR_MAGIC; end
          end
          PH_HDR_W, PH_HDR_H, PH_HDR_MAX, PH_P2_DATA: begin
            if (s.comment) begin
              if (file_byte == 8'h0a) s.comment = 1'b0;
            end else if (s.tstage == TOK_DIGIT || s.tstage == TOK_SIGN) begin
              if (digit) begin
                if (s.tstage == TOK_SIGN) s.acc = '0;
                v = 21'({s.acc, 3'b000}) + 21'({s.acc, 1'b0}) + 21'(dval);
                if (s.phase == PH_P2_DATA) s.acc = {1'b0, v[15:0]};
                else s.acc = (v > 21'h1FFFF) ? 17'h1FFFF : v[16:0];
                s.tstage = TOK_DIGIT;
              end else if (s.tstage == TOK_DIGIT) begin
                fin = 1'b1;
              end else begin
                failf = 1'b1; fcode = nerr;
              end
            end else if (space) begin
              s.tstage = TOK_SKIP;
            end else if (file_byte == 8'h23) begin
              s.comment = 1'b1;
            end else begin
              s.acc = '0;
              if (file_byte == 8'h2b || file_byte == 8'h2d) begin
                s.neg = (file_byte == 8'h2d);
                s.tstage = TOK_SIGN;
              end else if (digit) begin
                s.neg = 1'b0;
                s.acc = 17'(dval);
                s.tstage = TOK_DIGIT;
              end else begin
                failf = 1'b1; fcode = nerr;
              end
            end
          end
          PH_DATA8: begin
            px = 1'b1; pixv = {8'h00, file_byte};
          end
          PH_DATA16_HI: begin
            s.hold = file_byte; s.phase = PH_DATA16_LO;
          end
          PH_DATA16_LO: begin
            px = 1'b1; lo16 = 1'b1; pixv = {s.hold, file_byte};
          end
          default: begin
          end
        endcase
      end else if (pass == 2 && end_of_file && s.tstage == TOK_DIGIT &&
                   (s.phase == PH_HDR_W || s.phase == PH_HDR_H ||
                    s.phase == PH_HDR_MAX || s.phase == PH_P2_DATA)) begin
        fin = 1'b1;
      end

      // complete a number
      if (fin) begin
        sat13 = s.neg ? 13'd0 : ((s.acc > 17'd8191) ? 13'd8191 : s.acc[12:0]);
        consumed = 1'b1;
        unique case (s.phase)
          PH_HDR_W: begin s.w = sat13; s.phase = PH_HDR_H; consumed = 1'b0; end
          PH_HDR_H: begin s.h = sat13; s.phase = PH_HDR_MAX; consumed = 1'b0; end
          PH_HDR_MAX: begin
            s.m = s.neg ? 16'd0 : ((s.acc > 17'd65535) ? 16'hFFFF : s.acc[15:0]);
            if (s.w == '0 || s.h == '0 || s.m == '0) begin
              failf = 1'b1; fcode = ERR_ZERO;
            end else if (s.w > 13'(MAX_DIM) || s.h > 13'(MAX_DIM) ||
                         (!s.neg && s.acc > 17'd65535)) begin
              failf = 1'b1; fcode = ERR_LARGE;
            end else begin
              if (nres != 2'd2) begin
                res[nres[0]] = pgmog_mk(KIND_HEADER, '0, '0, ERR_MAGIC, 1'b0, s);
                nres = nres + 2'd1;
              end
              area = s.w * s.h;
              s.prem = area[24:0];
              s.rowb = 24'(area - 26'(s.w));
              s.col = '0;
              if (s.binfmt) s.phase = (s.m > 16'd255) ? PH_DATA16_HI : PH_DATA8;
              else begin s.phase = PH_P2_DATA; consumed = 1'b0; end
            end
          end
          PH_P2_DATA: begin
            negacc = 17'h10000 - s.acc;
            px = 1'b1;
            pixv = s.neg ? negacc[15:0] : s.acc[15:0];
            consumed = 1'b0;
          end
          default: begin
          end
        endcase
        s.acc = '0; s.neg = 1'b0; s.tstage = TOK_SKIP; s.comment = 1'b0;
        if (pass < 2) redo = !consumed;
      end

      // emit one cell
      if (px) begin
        if (nres != 2'd2) begin
          res[nres[0]] = pgmog_mk(KIND_CELL, s.rowb + 24'(s.col), pixv, ERR_MAGIC, 1'b0, s);
          nres = nres + 2'd1;
        end
        if (13'(s.col) + 13'd1 >= s.w) begin
          s.col = '0;
          s.rowb = s.rowb - 24'(s.w);
        end else begin
          s.col = s.col + 12'd1;
        end
        s.prem = s.prem - 25'd1;
        if (s.prem == '0) begin
          if (nres != 2'd2) begin
            res[nres[0]] = pgmog_mk(KIND_DONE, '0, '0, ERR_MAGIC, 1'b1, s);
            nres = nres + 2'd1;
          end
          s.phase = PH_DRAIN;
        end
        if (lo16 && s.phase == PH_DATA16_LO) s.phase = PH_DATA16_HI;
      end

      // report a failure
      if (failf) begin
        if (nres != 2'd2) begin
          res[nres[0]] = pgmog_mk(KIND_ERROR, '0, '0, fcode, 1'b1, s);
          nres = nres + 2'd1;
        end
        s.phase = PH_DRAIN;
      end
    end

    // end of file: close out and start over
    if (end_of_file) begin
      if (s.phase != PH_DRAIN) begin
        if (s.phase == PH_MAGIC_WS || s.phase == PH_MAGIC_P) fcode = ERR_MAGIC;
        else if (s.phase == PH_MAGIC_END || s.phase == PH_HDR_W ||
                 s.phase == PH_HDR_H || s.phase == PH_HDR_MAX) fcode = ERR_HEADER;
        else fcode = ERR_SHORT;
        if (nres != 2'd2) begin
          res[nres[0]] = pgmog_mk(KIND_ERROR, '0, '0, fcode, 1'b1, s);
          nres = nres + 2'd1;
        end
      end
      s = '0;
    end
    st_next = s;
  end

  assign push_count = take ? nres : 2'd0;
  assign push_rec0  = res[0];
  assign push_rec1  = res[1];

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (take) begin
      st <= st_next;
    end
  end

  a_eof_restart: assert property (@(posedge clk) disable iff (rst)
    take && end_of_file |=> st.phase == PH_MAGIC_WS && st.w == '0)
    else $error("parser did not restart after end of file");

endmodule

### src/pgmog_fifo.sv
// pgmog_fifo: small result queue, two writes and one read per cycle
// depends on pgmog_pkg

module pgmog_fifo import pgmog_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_count,
  input  pgmog_rec_t push_rec0,
  input  pgmog_rec_t push_rec1,
  input  logic       pop,
  output logic       not_empty,
  output logic       has_room,
  output pgmog_rec_t head
);

  pgmog_rec_t mem [FIFO_DEPTH];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count, count_next;
  logic       do_pop;

  assign not_empty  = (count != 3'd0);
  assign has_room   = (count <= 3'(FIFO_DEPTH - 2));
  assign head       = mem[rd_ptr];
  assign do_pop     = pop && not_empty;
  assign count_next = count + 3'(push_count) - 3'(do_pop);

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_count;
      rd_ptr <= rd_ptr + 2'(do_pop);
      count  <= count_next;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) mem[wr_ptr] <= push_rec0;
    if (push_count == 2'd2) mem[wr_ptr + 2'd1] <= push_rec1;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(FIFO_DEPTH))
    else $error("result queue over capacity");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push_count != 2'd0 |-> count - 3'(do_pop) + 3'(push_count) <= 3'(FIFO_DEPTH))
    else $error("push into full result queue");

endmodule

### src/pgmog_classify.sv
// pgmog_classify: threshold products, compare and output register
// depends on pgmog_pkg

module pgmog_classify import pgmog_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              rec_valid,
  input  pgmog_rec_t        rec,
  output logic              rec_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        result_kind,
  output logic [23:0]       cell_index,
  output logic signed [7:0] occupancy,
  output logic [12:0]       image_width,
  output logic [12:0]       image_height,
  output logic [15:0]       max_value,
  output logic [2:0]        error_code,
  output logic              last_result
);

  logic        negate;
  logic [15:0] occ_th, free_th;
  logic        a_valid, a_en, o_en;
  pgmog_rec_t  a_rec;
  logic signed [17:0] a_n, n_calc;
  logic [31:0] a_po, a_pf;
  logic signed [33:0] lhs, rhs_o, rhs_f;
  logic signed [7:0]  occ_calc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      negate <= 1'b0;
      occ_th <= OCC_RESET;
      free_th <= FREE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NEGATE: negate <= cfg_data[0];
        CFG_OCC:    occ_th <= cfg_data;
        CFG_FREE:   free_th <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign o_en    = !out_valid || out_ready;
  assign a_en    = !a_valid || o_en;
  assign rec_pop = a_en && rec_valid;

  assign n_calc = negate ? $signed({2'b00, rec.pix})
                         : $signed({2'b00, rec.m}) - $signed({2'b00, rec.pix});

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_en) begin
      a_valid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      a_rec <= rec;
      a_n   <= n_calc;
      a_po  <= occ_th * rec.m;
      a_pf  <= free_th * rec.m;
    end
  end

  // exact compare of n/m against the thresholds
  assign lhs   = $signed({a_n, 16'h0000});
  assign rhs_o = $signed({2'b00, a_po});
  assign rhs_f = $signed({2'b00, a_pf});

  always_comb begin
    if (a_rec.kind != KIND_CELL) occ_calc = 8'sd0;
    else if (lhs > rhs_o) occ_calc = 8'sd100;
    else if (lhs < rhs_f) occ_calc = 8'sd0;
    else occ_calc = -8'sd1;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_en) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_en) begin
      result_kind  <= a_rec.kind;
      cell_index   <= a_rec.idx;
      occupancy    <= occ_calc;
      image_width  <= a_rec.w;
      image_height <= a_rec.h;
      max_value    <= a_rec.m;
      error_code   <= a_rec.err;
      last_result  <= a_rec.last;
    end
  end

  a_noncell_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != KIND_CELL |-> occupancy == 8'sd0 && cell_index == '0)
    else $error("non-cell result carries cell data");

endmodule

### verif/tb_pgm_to_occupancy_grid_decoder_top.sv
// tb_pgm_to_occupancy_grid_decoder_top: self-checking bench for the pgm decoder
// depends on pgmog_pkg and pgm_to_occupancy_grid_decoder_top
`timescale 1ns / 1ps

module tb_pgm_to_occupancy_grid_decoder_top;
  import pgmog_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] idx;
    logic [7:0]  occ;
    logic [12:0] w;
    logic [12:0] h;
    logic [15:0] m;
    logic [2:0]  err;
    logic        last;
  } grid_result_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = CFG_NEGATE;
  logic [15:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [7:0] file_byte = '0;
  logic end_of_file = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] result_kind;
  logic [23:0] cell_index;
  logic signed [7:0] occupancy;
  logic [12:0] image_width, image_height;
  logic [15:0] max_value;
  logic [2:0] error_code;
  logic last_result;

  pgm_to_occupancy_grid_decoder_top dut (.*);

  always #5 clk = ~clk;

  // model copy of config and parser state
  logic        neg_mode;
  logic [15:0] occ_thr, free_thr;
  logic [3:0]  phase;
  logic        binfmt, comment, numneg;
  logic [16:0] acc;
  logic [1:0]  tstage;
  logic [12:0] wreg, hreg;
  logic [15:0] mreg;
  logic [11:0] col;
  logic [23:0] rowb;
  logic [7:0]  hold;
  logic [24:0] prem;

  grid_result_t expected_q[$];
  int fails = 0;
  longint cycles = 0;
  int out_wait = 0;

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    fails++;
  endtask

  function automatic void start_file();
    phase = PH_MAGIC_WS; binfmt = 0; comment = 0; acc = 0; numneg = 0;
    tstage = TOK_SKIP; wreg = 0; hreg = 0; mreg = 0; col = 0; rowb = 0;
    hold = 0; prem = 0;
  endfunction

  function automatic void push_result(logic [1:0] k, logic [23:0] i, logic [7:0] o,
                                      logic [2:0] e, logic l);
    grid_result_t r;
    r.kind = k; r.idx = i; r.occ = o; r.w = wreg; r.h = hreg; r.m = mreg;
    r.err = e; r.last = l;
    expected_q.push_back(r);
  endfunction

  function automatic void raise_error(logic [2:0] e);
    push_result(KIND_ERROR, '0, 8'd0, e, 1'b1);
    phase = PH_DRAIN;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // classify one sample and advance the raster position
  function automatic void emit_cell(logic [15:0] p);
    longint mm, n;
    logic [7:0] v;
    mm = mreg;
    n = neg_mode ? longint'(p) : mm - longint'(p);
    if (n * 65536 > longint'(occ_thr) * mm) v = 8'd100;
    else if (n * 65536 < longint'(free_thr) * mm) v = 8'd0;
    else v = 8'hFF;
    push_result(KIND_CELL, rowb + 24'(col), v, ERR_MAGIC, 1'b0);
    if (32'(col) + 1 >= 32'(wreg)) begin
      col = 0;
      rowb = rowb - 24'(wreg);
    end else begin
      col = col + 1;
    end
    prem = prem - 1;
    if (prem == 0) begin
      push_result(KIND_DONE, '0, 8'd0, ERR_MAGIC, 1'b1);
      phase = PH_DRAIN;
    end
  endfunction

  // completes a number; returns 1 when the ending byte is consumed
  function automatic bit close_number();
    logic [16:0] a;
    logic ng;
    logic [12:0] s13;
    a = acc; ng = numneg;
    s13 = ng ? 13'd0 : (a > 17'd8191 ? 13'd8191 : a[12:0]);
    acc = 0; numneg = 0; tstage = TOK_SKIP; comment = 0;
    case (phase)
      PH_HDR_W: begin wreg = s13; phase = PH_HDR_H; return 0; end
      PH_HDR_H: begin hreg = s13; phase = PH_HDR_MAX; return 0; end
      PH_HDR_MAX: begin
        mreg = ng ? 16'd0 : (a > 17'd65535 ? 16'hFFFF : a[15:0]);
        if (wreg == 0 || hreg == 0 || mreg == 0) begin
          raise_error(ERR_ZERO); return 1;
        end
        if (wreg > MAX_DIM || hreg > MAX_DIM || (!ng && a > 17'd65535)) begin
          raise_error(ERR_LARGE); return 1;
        end
        push_result(KIND_HEADER, '0, 8'd0, ERR_MAGIC, 1'b0);
        prem = 25'(wreg) * 25'(hreg);
        rowb = 24'(hreg - 1) * 24'(wreg);
        col = 0;
        if (binfmt) begin
          phase = mreg > 255 ? PH_DATA16_HI : PH_DATA8;
          return 1;
        end
        phase = PH_P2_DATA;
        return 0;
      end
      PH_P2_DATA: begin
        emit_cell(ng ? 16'(17'h10000 - a) : a[15:0]);
        return 0;
      end
      default: return 1;
    endcase
  endfunction

  function automatic void add_digit(logic [7:0] c);
    logic [31:0] v;
    v = 32'(acc) * 10 + 32'(c - 8'h30);
    if (phase == PH_P2_DATA) acc = 17'(v[15:0]);
    else acc = v > 32'h1FFFF ? 17'h1FFFF : v[16:0];
  endfunction

  function automatic bit parse_byte(logic [7:0] c);
    bit dig;
    logic [2:0] nerr;
    dig = c >= 8'h30 && c <= 8'h39;
    nerr = phase == PH_P2_DATA ? ERR_SHORT : ERR_HEADER;
    case (phase)
      PH_MAGIC_WS: begin
        if (c == "P") phase = PH_MAGIC_P;
        else if (!is_blank(c)) raise_error(ERR_MAGIC);
      end
      PH_MAGIC_P: begin
        if (c == "5" || c == "2") begin binfmt = c == "5"; phase = PH_MAGIC_END; end
        else raise_error(ERR_MAGIC);
      end
      PH_MAGIC_END: begin
        if (is_blank(c)) begin phase = PH_HDR_W; tstage = TOK_SKIP; end
        else raise_error(ERR_MAGIC);
      end
      PH_HDR_W, PH_HDR_H, PH_HDR_MAX, PH_P2_DATA: begin
        if (comment) begin
          if (c == 8'h0A) comment = 0;
        end else if (tstage == TOK_DIGIT) begin
          if (dig) add_digit(c);
          else return close_number();
        end else if (tstage == TOK_SIGN) begin
          if (dig) begin acc = 0; add_digit(c); tstage = TOK_DIGIT; end
          else raise_error(nerr);
        end else if (is_blank(c)) begin
        end else if (c == "#") begin
          comment = 1;
        end else begin
          acc = 0;
          if (c == "+" || c == "-") begin numneg = c == "-"; tstage = TOK_SIGN; end
          else if (dig) begin numneg = 0; add_digit(c); tstage = TOK_DIGIT; end
          else raise_error(nerr);
        end
      end
      PH_DATA8: emit_cell(16'(c));
      PH_DATA16_HI: begin hold = c; phase = PH_DATA16_LO; end
      PH_DATA16_LO: begin
        emit_cell({hold, c});
        if (phase == PH_DATA16_LO) phase = PH_DATA16_HI;
      end
      default: ;
    endcase
    return 1;
  endfunction

  function automatic void predict_byte(logic [7:0] c, logic eof);
    bit dummy;
    if (!parse_byte(c)) dummy = parse_byte(c);
    if (eof) begin
      if ((phase == PH_HDR_W || phase == PH_HDR_H || phase == PH_HDR_MAX ||
           phase == PH_P2_DATA) && tstage == TOK_DIGIT) dummy = close_number();
      if (phase != PH_DRAIN) begin
        if (phase == PH_MAGIC_WS || phase == PH_MAGIC_P) raise_error(ERR_MAGIC);
        else if (phase <= PH_HDR_MAX) raise_error(ERR_HEADER);
        else raise_error(ERR_SHORT);
      end
      start_file();
    end
  endfunction

  // send one request, with a random gap first; valid drops only for a gap
  task automatic send_byte(input logic [7:0] c, input logic eof, input bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 11) : 0);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; file_byte <= c; end_of_file <= eof;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(c, eof);
  endtask

  task automatic send_text(input string s, input bit eof_last = 1);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], eof_last && i == s.len() - 1);
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [15:0] val);
    wait_idle();
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_NEGATE: neg_mode = val[0];
      CFG_OCC:    occ_thr = val;
      default:    free_thr = val;
    endcase
  endtask

  // binary file with random samples
  task automatic send_p5(input int w, input int h, input int mx);
    string hdr;
    int n;
    hdr = $sformatf("P5\n%0d %0d\n%0d\n", w, h, mx);
    send_text(hdr, 0);
    n = w * h * (mx > 255 ? 2 : 1);
    for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), i == n - 1);
  endtask

  task automatic send_p2(input int w, input int h, input int mx);
    string s;
    s = $sformatf("P2 # note\n%0d %0d %0d\n", w, h, mx);
    for (int i = 0; i < w * h; i++)
      s = {s, $sformatf("%0d ", $urandom_range(0, mx + 2))};
    send_text(s);
  endtask

  // result checker
  always @(posedge clk) begin
    grid_result_t e;
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) report_mismatch("unexpected result");
      else begin
        e = expected_q.pop_front();
        if (result_kind !== e.kind) report_mismatch("result_kind");
        if (cell_index !== e.idx) report_mismatch("cell_index");
        if (occupancy !== e.occ) report_mismatch("occupancy");
        if (image_width !== e.w) report_mismatch("image_width");
        if (image_height !== e.h) report_mismatch("image_height");
        if (max_value !== e.m) report_mismatch("max_value");
        if (error_code !== e.err) report_mismatch("error_code");
        if (last_result !== e.last) report_mismatch("last_result");
      end
    end
    if (out_wait > 0) begin
      out_wait <= out_wait - 1;
      out_ready <= 0;
    end else if ($urandom_range(0, 3) == 0) begin
      out_wait <= $urandom_range(0, 11);
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
    if (cycles > 2000000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_headers();
    send_text("P5\n2 2\n255\n", 0);
    send_byte(8'h00, 0); send_byte(8'hFF, 0); send_byte(8'h80, 0); send_byte(8'h7F, 1);
    send_text("  P3\n");
    send_text("P");
    send_text("P5");
    send_text("P5\n0 3 9\n");
    send_text("P5\n5000 2 9\n");
    send_text("P2\n1 1 -4\n");
    send_text("P2\n1 1 70000\n");
    send_text("P2 x\n");
    send_text("P2\n2 +\n");
    send_text("P2\n1 2 9\n5 #c\n-3");
    send_text("P2\n2 2 9\n1 z");
    send_text("P2\n1 1 9\n4 junk after done");
    send_text("P5\n3 1 9 ");
  endtask

  task automatic test_pixels();
    send_p5(3, 2, 255);
    send_p5(2, 2, 65535);
    send_p2(3, 3, 20);
  endtask

  task automatic test_thresholds();
    write_cfg(CFG_NEGATE, 16'd1);
    write_cfg(CFG_OCC, 16'hFFFF);
    write_cfg(CFG_FREE, 16'd0);
    send_p5(4, 2, 255);
    write_cfg(CFG_OCC, 16'd0);
    write_cfg(CFG_FREE, 16'hFFFF);
    send_p2(2, 2, 9);
    write_cfg(CFG_NEGATE, 16'd0);
    write_cfg(CFG_OCC, 16'd30000);
    write_cfg(CFG_FREE, 16'd20000);
    send_p5(3, 3, 1000);
  endtask

  task automatic test_random();
    int sel;
    for (int f = 0; f < 15; f++) begin
      sel = $urandom_range(0, 9);
      if (sel < 4) send_p5($urandom_range(1, 5), $urandom_range(1, 4),
                           $urandom_range(0, 1) ? $urandom_range(1, 255)
                                                : $urandom_range(256, 65535));
      else if (sel < 8) send_p2($urandom_range(1, 4), $urandom_range(1, 3),
                                $urandom_range(1, 300));
      else for (int i = 0; i < 8; i++) send_byte(8'($urandom_range(0, 255)), i == 7);
      if (f == 7) begin
        write_cfg(CFG_NEGATE, 16'($urandom_range(0, 1)));
        write_cfg(CFG_OCC, 16'($urandom_range(0, 65535)));
        write_cfg(CFG_FREE, 16'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin
    neg_mode = 0; occ_thr = OCC_RESET; free_thr = FREE_RESET;
    start_file();
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_headers();
    test_pixels();
    wait_idle();
    test_thresholds();
    test_random();
    wait_idle();
    if (fails == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
